### hdl/ffbta_pkg.sv
// ----------------------------------------------------------------------------
// ffbta_pkg
// shared types, codes and defaults of the first-fit boundary-tag allocator
// ----------------------------------------------------------------------------
package ffbta_pkg;

    localparam int HEAP_BYTES_DEF    = 32768;
    localparam int GRANULE_BYTES_DEF = 16;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_FIT = 1'b1;

    // tag flag bits
    localparam logic [2:0] TAG_NONE = 3'b000;
    localparam logic [2:0] TAG_HDR  = 3'b001;
    localparam logic [2:0] TAG_FTR  = 3'b010;
    localparam logic [2:0] TAG_USED = 3'b100;

    typedef struct packed {
        logic        req_type;
        logic [14:0] request_size;
        logic [14:0] block_address;
    } alloc_req_t;

    typedef struct packed {
        logic [14:0] result_address;
        logic        status;
    } alloc_rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_ARD,
        OP_ACHK,
        OP_S1,
        OP_S2,
        OP_S3,
        OP_S4,
        OP_E1,
        OP_E2,
        OP_FAIL,
        OP_FRD,
        OP_F1,
        OP_F2,
        OP_F4,
        OP_F5,
        OP_FRR,
        OP_F6,
        OP_F7,
        OP_F8,
        OP_P1,
        OP_P2
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic free_req;
        logic addr_ok;
        logic live;
        logic fit;
        logic split;
        logic hok;
        logic hpos;
        logic lmerge;
        logic rhas;
        logic rmerge;
    } dp_stat_t;

endpackage

### hdl/ffbta_dp.sv
// ----------------------------------------------------------------------------
// ffbta_dp
// tag store, free list head and address arithmetic driven by the controller
// ----------------------------------------------------------------------------
module ffbta_dp
    import ffbta_pkg::*;
#(
    parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
    parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  alloc_req_t request,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output alloc_rsp_t result
);

    localparam int NGRAN = HEAP_BYTES / GRANULE_BYTES;
    localparam int GW    = $clog2(NGRAN);
    localparam int LW    = $clog2(NGRAN + 1);
    localparam int SH    = $clog2(GRANULE_BYTES);
    localparam int AW    = 16 - SH;
    localparam int CW    = ((GW > AW) ? GW : AW) + 2;

    localparam logic [LW-1:0] NIL  = LW'(NGRAN);
    localparam logic [GW-1:0] LAST = GW'(NGRAN - 1);
    localparam logic [GW-1:0] FULL = GW'(NGRAN - 2);
    localparam logic [CW-1:0] NG_W = CW'(NGRAN);

    typedef struct packed {
        logic [2:0]    flags;
        logic [GW-1:0] size;
    } tag_t;

    tag_t          tag_mem  [NGRAN];
    logic [LW-1:0] succ_mem [NGRAN];
    logic [LW-1:0] prev_mem [NGRAN];

    tag_t          q_tag_reg;
    logic [LW-1:0] q_succ_reg, q_prev_reg;

    alloc_req_t    req_reg;
    logic [AW-1:0] a_reg;
    logic [LW-1:0] cur_reg, cnt_reg, pv_reg, sc_reg, head_reg;
    logic [GW-1:0] p_reg, r_reg, h_reg, f_reg, start_reg, end_reg, lh_reg, uf_reg;
    logic [GW-1:0] clr_reg;
    logic [14:0]   res_addr_reg;
    logic          res_stat_reg;

    logic          rd_en;
    logic [GW-1:0] rd_addr;
    logic          tag_we, succ_we, prev_we;
    logic [GW-1:0] tag_wa, succ_wa, prev_wa;
    tag_t          tag_wd;
    logic [LW-1:0] succ_wd, prev_wd;
    logic          head_we;
    logic [LW-1:0] head_wd;

    logic [15:0]   rsum;
    logic [AW-1:0] a_raw, a_calc;
    logic [CW-1:0] hw, q_size_w, cur_w, a_w, h_w, f_w, p_w, u_w;
    logic [CW-1:0] f_calc, lh_calc, uf_calc, r_calc;
    logic [CW+SH-1:0] gaddr;
    logic [GW-1:0] a_g, rem_g, sz_g, u_g;

    // request decode
    assign rsum   = {1'b0, req_reg.request_size} + 16'(GRANULE_BYTES - 1);
    assign a_raw  = AW'(rsum >> SH);
    assign a_calc = (a_raw == '0) ? AW'(1) : a_raw;
    assign hw     = CW'(req_reg.block_address >> SH) - CW'(1);

    assign q_size_w = CW'(q_tag_reg.size);
    assign cur_w    = CW'(cur_reg);
    assign a_w      = CW'(a_reg);
    assign h_w      = CW'(h_reg);
    assign f_w      = CW'(f_reg);
    assign p_w      = CW'(p_reg);
    assign u_w      = f_w + CW'(1);
    assign u_g      = GW'(u_w);

    assign f_calc  = h_w + q_size_w + CW'(1);
    assign lh_calc = h_w - CW'(2) - q_size_w;
    assign uf_calc = u_w + q_size_w + CW'(1);
    assign r_calc  = cur_w + a_w + CW'(2);
    assign gaddr   = {cur_w + CW'(1), SH'(0)};

    assign a_g   = GW'(a_reg);
    assign rem_g = GW'(p_w - a_w - CW'(2));
    assign sz_g  = end_reg - start_reg - GW'(1);

    always_comb
    begin
        stat.clr_done = (clr_reg == LAST);
        stat.free_req = (req_reg.req_type == REQ_FREE);
        stat.addr_ok  = (req_reg.block_address[SH-1:0] == '0)
                        && (req_reg.block_address >= 15'(GRANULE_BYTES))
                        && (hw < NG_W);
        stat.live     = (cur_reg < NIL) && (cnt_reg < NIL);
        stat.fit      = (q_tag_reg.flags == TAG_HDR) && (q_size_w >= a_w)
                        && (cur_w + q_size_w + CW'(1) < NG_W);
        stat.split    = (q_size_w >= a_w + CW'(3));
        stat.hok      = (q_tag_reg.flags == (TAG_HDR | TAG_USED)) && (f_calc < NG_W);
        stat.hpos     = (h_reg != '0);
        stat.lmerge   = (q_tag_reg.flags == TAG_FTR) && (h_w >= q_size_w + CW'(2));
        stat.rhas     = (u_w < NG_W);
        stat.rmerge   = (q_tag_reg.flags == TAG_HDR) && (uf_calc < NG_W);
    end

    // memory port steering per command
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        tag_we  = 1'b0;
        tag_wa  = '0;
        tag_wd  = '0;
        succ_we = 1'b0;
        succ_wa = '0;
        succ_wd = '0;
        prev_we = 1'b0;
        prev_wa = '0;
        prev_wd = '0;
        head_we = 1'b0;
        head_wd = '0;
        case (cmd.op)
            OP_CLEAR:
            begin
                tag_we  = 1'b1;
                tag_wa  = clr_reg;
                succ_we = 1'b1;
                succ_wa = clr_reg;
                prev_we = 1'b1;
                prev_wa = clr_reg;
                if (clr_reg == '0)
                begin
                    tag_wd  = '{flags: TAG_HDR, size: FULL};
                    succ_wd = NIL;
                    prev_wd = NIL;
                end
                else if (clr_reg == LAST)
                begin
                    tag_wd = '{flags: TAG_FTR, size: FULL};
                end
            end
            OP_ARD:
            begin
                rd_en   = 1'b1;
                rd_addr = GW'(cur_reg);
            end
            OP_S1:
            begin
                tag_we  = 1'b1;
                tag_wa  = GW'(cur_reg);
                tag_wd  = '{flags: TAG_HDR | TAG_USED, size: a_g};
                succ_we = 1'b1;
                succ_wa = GW'(cur_reg);
                succ_wd = NIL;
                prev_we = 1'b1;
                prev_wa = GW'(cur_reg);
                prev_wd = NIL;
            end
            OP_S2:
            begin
                tag_we  = 1'b1;
                tag_wa  = GW'(cur_w + a_w + CW'(1));
                tag_wd  = '{flags: TAG_FTR | TAG_USED, size: a_g};
                succ_we = 1'b1;
                succ_wa = r_reg;
                succ_wd = sc_reg;
                prev_we = 1'b1;
                prev_wa = r_reg;
                prev_wd = pv_reg;
            end
            OP_S3:
            begin
                tag_we = 1'b1;
                tag_wa = r_reg;
                tag_wd = '{flags: TAG_HDR, size: rem_g};
            end
            OP_S4:
            begin
                tag_we  = 1'b1;
                tag_wa  = GW'(cur_w + p_w + CW'(1));
                tag_wd  = '{flags: TAG_FTR, size: rem_g};
                succ_we = (pv_reg < NIL);
                succ_wa = GW'(pv_reg);
                succ_wd = LW'(r_reg);
                head_we = !(pv_reg < NIL);
                head_wd = LW'(r_reg);
                prev_we = (sc_reg < NIL);
                prev_wa = GW'(sc_reg);
                prev_wd = LW'(r_reg);
            end
            OP_E1:
            begin
                succ_we = (pv_reg < NIL);
                succ_wa = GW'(pv_reg);
                succ_wd = sc_reg;
                head_we = !(pv_reg < NIL);
                head_wd = sc_reg;
                prev_we = (sc_reg < NIL);
                prev_wa = GW'(sc_reg);
                prev_wd = pv_reg;
                tag_we  = 1'b1;
                tag_wa  = GW'(cur_reg);
                tag_wd  = '{flags: TAG_HDR | TAG_USED, size: p_reg};
            end
            OP_E2:
            begin
                succ_we = 1'b1;
                succ_wa = GW'(cur_reg);
                succ_wd = NIL;
                prev_we = 1'b1;
                prev_wa = GW'(cur_reg);
                prev_wd = NIL;
                tag_we  = 1'b1;
                tag_wa  = GW'(cur_w + p_w + CW'(1));
                tag_wd  = '{flags: TAG_FTR | TAG_USED, size: p_reg};
            end
            OP_FRD:
            begin
                rd_en   = 1'b1;
                rd_addr = h_reg;
            end
            OP_F1:
            begin
                rd_en   = 1'b1;
                rd_addr = h_reg - GW'(1);
            end
            OP_F2:
            begin
                rd_en   = 1'b1;
                rd_addr = GW'(lh_calc);
            end
            OP_F4, OP_F7:
            begin
                succ_we = (q_prev_reg < NIL);
                succ_wa = GW'(q_prev_reg);
                succ_wd = q_succ_reg;
                head_we = !(q_prev_reg < NIL);
                head_wd = q_succ_reg;
                prev_we = (q_succ_reg < NIL);
                prev_wa = GW'(q_succ_reg);
                prev_wd = q_prev_reg;
                tag_we  = 1'b1;
                tag_wa  = (cmd.op == OP_F4) ? (h_reg - GW'(1)) : f_reg;
                tag_wd  = '0;
            end
            OP_F5, OP_F8:
            begin
                succ_we = 1'b1;
                succ_wa = (cmd.op == OP_F5) ? lh_reg : u_g;
                succ_wd = NIL;
                prev_we = 1'b1;
                prev_wa = (cmd.op == OP_F5) ? lh_reg : u_g;
                prev_wd = NIL;
                tag_we  = 1'b1;
                tag_wa  = (cmd.op == OP_F5) ? h_reg : u_g;
                tag_wd  = '0;
            end
            OP_FRR:
            begin
                rd_en   = 1'b1;
                rd_addr = u_g;
            end
            OP_P1:
            begin
                tag_we  = 1'b1;
                tag_wa  = start_reg;
                tag_wd  = '{flags: TAG_HDR, size: sz_g};
                succ_we = 1'b1;
                succ_wa = start_reg;
                succ_wd = head_reg;
                prev_we = 1'b1;
                prev_wa = start_reg;
                prev_wd = NIL;
            end
            OP_P2:
            begin
                tag_we  = 1'b1;
                tag_wa  = end_reg;
                tag_wd  = '{flags: TAG_FTR, size: sz_g};
                prev_we = (head_reg < NIL);
                prev_wa = GW'(head_reg);
                prev_wd = LW'(start_reg);
                head_we = 1'b1;
                head_wd = LW'(start_reg);
            end
            default:
            begin
            end
        endcase
    end

    // tag store, read data registered
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
        if (succ_we)
        begin
            succ_mem[succ_wa] <= succ_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (rd_en)
        begin
            q_tag_reg  <= tag_mem[rd_addr];
            q_succ_reg <= succ_mem[rd_addr];
            q_prev_reg <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            if (head_we)
            begin
                head_reg <= head_wd;
            end
            if (cmd.op == OP_CLEAR)
            begin
                clr_reg <= clr_reg + GW'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                a_reg        <= a_calc;
                cur_reg      <= head_reg;
                cnt_reg      <= '0;
                h_reg        <= GW'(hw);
                res_addr_reg <= '0;
                res_stat_reg <= STATUS_OK;
            end
            OP_ACHK:
            begin
                if (stat.fit)
                begin
                    p_reg  <= q_tag_reg.size;
                    pv_reg <= q_prev_reg;
                    sc_reg <= q_succ_reg;
                    r_reg  <= GW'(r_calc);
                end
                else
                begin
                    cur_reg <= q_succ_reg;
                    cnt_reg <= cnt_reg + LW'(1);
                end
            end
            OP_S1, OP_E1:
            begin
                res_addr_reg <= gaddr[14:0];
            end
            OP_FAIL:
            begin
                res_stat_reg <= STATUS_NO_FIT;
            end
            OP_F1:
            begin
                f_reg     <= GW'(f_calc);
                start_reg <= h_reg;
                end_reg   <= GW'(f_calc);
            end
            OP_F2:
            begin
                lh_reg <= GW'(lh_calc);
            end
            OP_F4:
            begin
                start_reg <= lh_reg;
            end
            OP_F6:
            begin
                uf_reg <= GW'(uf_calc);
            end
            OP_F8:
            begin
                end_reg <= uf_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign result.result_address = res_addr_reg;
    assign result.status         = res_stat_reg;

endmodule

### hdl/ffbta_ctrl.sv
// ----------------------------------------------------------------------------
// ffbta_ctrl
// sequencer for the allocate walk, block split and free coalescing
// ----------------------------------------------------------------------------
module ffbta_ctrl
    import ffbta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output logic     busy,
    output logic     done,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LOAD, S_ARD, S_ACHK, S_S1, S_S2, S_S3, S_S4,
        S_E1, S_E2, S_FAIL, S_FRD, S_F1, S_F2, S_F4, S_F5, S_FRR, S_F6,
        S_F7, S_F8, S_P1, S_P2, S_DONE
    } state_t;

    state_t state_reg, state_next;
    dp_op_t op_reg, op_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    function automatic dp_op_t op_of(input state_t s);
        dp_op_t o;
        case (s)
            S_CLR:   o = OP_CLEAR;
            S_LOAD:  o = OP_LOAD;
            S_ARD:   o = OP_ARD;
            S_ACHK:  o = OP_ACHK;
            S_S1:    o = OP_S1;
            S_S2:    o = OP_S2;
            S_S3:    o = OP_S3;
            S_S4:    o = OP_S4;
            S_E1:    o = OP_E1;
            S_E2:    o = OP_E2;
            S_FAIL:  o = OP_FAIL;
            S_FRD:   o = OP_FRD;
            S_F1:    o = OP_F1;
            S_F2:    o = OP_F2;
            S_F4:    o = OP_F4;
            S_F5:    o = OP_F5;
            S_FRR:   o = OP_FRR;
            S_F6:    o = OP_F6;
            S_F7:    o = OP_F7;
            S_F8:    o = OP_F8;
            S_P1:    o = OP_P1;
            S_P2:    o = OP_P2;
            default: o = OP_NONE;
        endcase
        return o;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:   state_next = stat.clr_done ? S_IDLE : S_CLR;
            S_IDLE,
            S_DONE:  state_next = start ? S_LOAD : S_IDLE;
            S_LOAD:
            begin
                if (!stat.free_req)
                    state_next = S_ARD;
                else
                    state_next = stat.addr_ok ? S_FRD : S_DONE;
            end
            S_ARD:   state_next = stat.live ? S_ACHK : S_FAIL;
            S_ACHK:
            begin
                if (stat.fit)
                    state_next = stat.split ? S_S1 : S_E1;
                else
                    state_next = S_ARD;
            end
            S_S1:    state_next = S_S2;
            S_S2:    state_next = S_S3;
            S_S3:    state_next = S_S4;
            S_S4:    state_next = S_DONE;
            S_E1:    state_next = S_E2;
            S_E2:    state_next = S_DONE;
            S_FAIL:  state_next = S_DONE;
            S_FRD:   state_next = S_F1;
            S_F1:
            begin
                if (!stat.hok)
                    state_next = S_DONE;
                else
                    state_next = stat.hpos ? S_F2 : S_FRR;
            end
            S_F2:    state_next = stat.lmerge ? S_F4 : S_FRR;
            S_F4:    state_next = S_F5;
            S_F5:    state_next = S_FRR;
            S_FRR:   state_next = stat.rhas ? S_F6 : S_P1;
            S_F6:    state_next = stat.rmerge ? S_F7 : S_P1;
            S_F7:    state_next = S_F8;
            S_F8:    state_next = S_P1;
            S_P1:    state_next = S_P2;
            S_P2:    state_next = S_DONE;
            default: state_next = S_IDLE;
        endcase
        op_next   = op_of(state_next);
        busy_next = !(state_next == S_IDLE || state_next == S_DONE);
        done_next = (state_next == S_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            op_reg    <= OP_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign cmd.op = op_reg;

`ifndef SYNTH
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("accepted request did not make the block busy");

    a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> (!done_reg && busy_reg))
        else $error("activity during tag store initialization");
`endif

endmodule

### hdl/first_fit_boundary_tag_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator
// heap allocator with header/footer tags and a LIFO explicit free list
// ----------------------------------------------------------------------------
//
//  channel   | signals                  | handshake
//  ----------+--------------------------+-------------------------------------
//  request   | start, busy, request     | taken when start high and busy low
//  result    | done, result             | one cycle strobe, cannot be held off
//
//  after reset the tag store is initialized one granule per cycle, all
//  HEAP_BYTES / GRANULE_BYTES granules (2048 at defaults), with busy high
//  allocate: a read and a fit check per free-list entry visited, then an exact
//  fit, no fit or split finish; free: address check, header read and check,
//  optional left and right neighbor merges, then a push onto the free-list head
//  each step makes at most one read of the single-read-port tag store
//  result strobes in the cycle after the last step; a new request may start then
//  GRANULE_BYTES is taken as a power of two
//
module first_fit_boundary_tag_allocator
    import ffbta_pkg::*;
#(
    parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
    parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  alloc_req_t request,
    output logic       done,
    output alloc_rsp_t result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     accept;

    // request enters when the sequencer is free
    assign accept = start & ~busy;

    // sequencer
    ffbta_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // tag store and list arithmetic
    ffbta_dp #(
        .HEAP_BYTES    (HEAP_BYTES),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule
